// ----- rtl/hhlp_pkg.sv -----
`default_nettype none

package hhlp_pkg;

  localparam int LengthMax = 8191;
  localparam int CountW    = $clog2(LengthMax + 1);
  localparam int LenW      = 13;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLow   = 8'h21;
  localparam logic [7:0] ChHigh  = 8'h7E;

  typedef enum logic [2:0] {
    PH_START,
    PH_NAME,
    PH_COLON,
    PH_GAP,
    PH_VALUE,
    PH_WAITLF,
    PH_SKIP,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ROLE_IGNORED,
    ROLE_NAME,
    ROLE_VALUE,
    ROLE_DELIM
  } role_t;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_LINE_DONE,
    EV_HDRS_DONE,
    EV_LINE_ERROR,
    EV_INCOMPLETE
  } event_t;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } hdr_item_t;

  typedef struct packed {
    role_t           byte_role;
    event_t          event_res;
    logic [LenW-1:0] name_length;
    logic [LenW-1:0] value_length;
  } res_item_t;

  typedef struct packed {
    logic zero;
    logic name;
    logic vchar;
    logic gap;
    logic cr;
    logic lf;
    logic colon;
  } class_t;

endpackage

`default_nettype wire

// ----- rtl/hhlp_classify.sv -----
`default_nettype none

module hhlp_classify (
  input  wire logic [7:0]      data_byte,
  output hhlp_pkg::class_t     cls
);

  logic vchar;

  // printable range; every printable byte but the colon is a token byte
  assign vchar = (data_byte >= hhlp_pkg::ChLow) && (data_byte <= hhlp_pkg::ChHigh);

  always_comb begin
    cls       = '0;
    cls.zero  = (data_byte == 8'h00);
    cls.vchar = vchar;
    cls.colon = (data_byte == hhlp_pkg::ChColon);
    cls.name  = vchar && (data_byte != hhlp_pkg::ChColon);
    cls.gap   = (data_byte == hhlp_pkg::ChSpace) || (data_byte == hhlp_pkg::ChTab);
    cls.cr    = (data_byte == hhlp_pkg::ChCr);
    cls.lf    = (data_byte == hhlp_pkg::ChLf);
  end

endmodule

`default_nettype wire

// ----- rtl/hhlp_core.sv -----
`default_nettype none

module hhlp_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic              command,
  input  hhlp_pkg::class_t       cls,
  output hhlp_pkg::res_item_t    res_item
);

  hhlp_pkg::phase_t                 phase, phase_next, ph_step;
  logic [hhlp_pkg::CountW-1:0]      name_count, name_count_next, nc_step;
  logic [hhlp_pkg::CountW-1:0]      value_count, value_count_next, vc_step;
  hhlp_pkg::role_t                  role_raw;
  logic                             line_done, err, incomplete;

  function automatic logic [hhlp_pkg::CountW-1:0] bump(
    input logic [hhlp_pkg::CountW-1:0] n
  );
    logic [hhlp_pkg::CountW-1:0] top;
    top = hhlp_pkg::CountW'(hhlp_pkg::LengthMax);
    return (n < top) ? n + 1'b1 : top;
  endfunction

  // per-byte decision
  always_comb begin
    role_raw   = hhlp_pkg::ROLE_IGNORED;
    line_done  = 1'b0;
    err        = 1'b0;
    incomplete = 1'b0;
    ph_step    = phase;
    nc_step    = name_count;
    vc_step    = value_count;
    if (command) begin
      ph_step = hhlp_pkg::PH_START;
      nc_step = '0;
      vc_step = '0;
    end else if (phase == hhlp_pkg::PH_DONE) begin
      ph_step = phase;
    end else if (cls.zero) begin
      incomplete = 1'b1;
    end else begin
      case (phase)
        hhlp_pkg::PH_START: begin
          if (cls.name) begin
            ph_step  = hhlp_pkg::PH_NAME;
            nc_step  = hhlp_pkg::CountW'(1);
            vc_step  = '0;
            role_raw = hhlp_pkg::ROLE_NAME;
          end else if (cls.cr || cls.lf) begin
            ph_step  = hhlp_pkg::PH_DONE;
            role_raw = hhlp_pkg::ROLE_DELIM;
          end else begin
            err = 1'b1;
          end
        end
        hhlp_pkg::PH_NAME: begin
          if (cls.name) begin
            nc_step  = bump(name_count);
            role_raw = hhlp_pkg::ROLE_NAME;
          end else if (cls.colon) begin
            ph_step  = hhlp_pkg::PH_COLON;
            role_raw = hhlp_pkg::ROLE_DELIM;
          end else begin
            err = 1'b1;
          end
        end
        hhlp_pkg::PH_COLON, hhlp_pkg::PH_GAP: begin
          if (phase == hhlp_pkg::PH_COLON && cls.colon) begin
            role_raw = hhlp_pkg::ROLE_DELIM;
          end else if (cls.gap) begin
            ph_step  = hhlp_pkg::PH_GAP;
            role_raw = hhlp_pkg::ROLE_DELIM;
          end else if (cls.vchar) begin
            ph_step  = hhlp_pkg::PH_VALUE;
            vc_step  = hhlp_pkg::CountW'(1);
            role_raw = hhlp_pkg::ROLE_VALUE;
          end else if (cls.cr) begin
            ph_step  = hhlp_pkg::PH_WAITLF;
            role_raw = hhlp_pkg::ROLE_DELIM;
          end else if (cls.lf) begin
            role_raw  = hhlp_pkg::ROLE_DELIM;
            line_done = 1'b1;
          end else begin
            err = 1'b1;
          end
        end
        hhlp_pkg::PH_VALUE: begin
          if (cls.vchar || cls.gap) begin
            vc_step  = bump(value_count);
            role_raw = hhlp_pkg::ROLE_VALUE;
          end else if (cls.cr) begin
            ph_step  = hhlp_pkg::PH_WAITLF;
            role_raw = hhlp_pkg::ROLE_DELIM;
          end else if (cls.lf) begin
            role_raw  = hhlp_pkg::ROLE_DELIM;
            line_done = 1'b1;
          end else begin
            err = 1'b1;
          end
        end
        hhlp_pkg::PH_WAITLF: begin
          if (cls.lf) begin
            role_raw  = hhlp_pkg::ROLE_DELIM;
            line_done = 1'b1;
          end else begin
            err = 1'b1;
          end
        end
        default: begin
          if (cls.lf) begin
            ph_step  = hhlp_pkg::PH_START;
            role_raw = hhlp_pkg::ROLE_DELIM;
          end
        end
      endcase
    end
  end

  // next state
  always_comb begin
    phase_next       = ph_step;
    name_count_next  = nc_step;
    value_count_next = vc_step;
    if (line_done || err) begin
      name_count_next  = '0;
      value_count_next = '0;
      phase_next       = (err && !cls.lf) ? hhlp_pkg::PH_SKIP : hhlp_pkg::PH_START;
    end
  end

  // outputs
  always_comb begin
    res_item              = '0;
    res_item.byte_role    = err ? hhlp_pkg::ROLE_IGNORED : role_raw;
    res_item.event_res    = hhlp_pkg::EV_NONE;
    if (line_done) begin
      res_item.event_res    = hhlp_pkg::EV_LINE_DONE;
      res_item.name_length  = hhlp_pkg::LenW'(name_count);
      res_item.value_length = hhlp_pkg::LenW'(value_count);
    end else if (err) begin
      res_item.event_res = hhlp_pkg::EV_LINE_ERROR;
    end else if (incomplete) begin
      res_item.event_res = hhlp_pkg::EV_INCOMPLETE;
    end else if (!command && phase == hhlp_pkg::PH_START && ph_step == hhlp_pkg::PH_DONE) begin
      res_item.event_res = hhlp_pkg::EV_HDRS_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= hhlp_pkg::PH_START;
      name_count  <= '0;
      value_count <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      name_count  <= name_count_next;
      value_count <= value_count_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/http_header_line_parser.sv -----
`default_nettype none

// HTTP header line parser. Takes one header byte per item and returns one
// result item per byte: the byte's role, a line event, and on a finished line
// its name and value lengths (saturating). One item per cycle sustained while
// the result side is ready; each item waits in the input register, where the
// phase machine and its two counters update, and then sits in the result
// register until taken.

module http_header_line_parser (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 hdr_valid,
  output      logic                 hdr_ready,
  input  hhlp_pkg::hdr_item_t       hdr,
  output      logic                 res_valid,
  input  wire logic                 res_ready,
  output hhlp_pkg::res_item_t       res
);

  logic                 s1_valid;
  hhlp_pkg::hdr_item_t  s1_item;
  logic                 advance;
  hhlp_pkg::class_t     cls;
  hhlp_pkg::res_item_t  res_next;

  assign advance   = s1_valid && (!res_valid || res_ready);
  assign hdr_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (hdr_ready) begin
      s1_valid <= hdr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_ready && hdr_valid) begin
      s1_item <= hdr;
    end
  end

  hhlp_classify u_classify (
    .data_byte (s1_item.data_byte),
    .cls       (cls)
  );

  hhlp_core u_core (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .command  (s1_item.command),
    .cls      (cls),
    .res_item (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hhlp_checker.sv -----
`default_nettype none

module hhlp_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 hdr_valid,
  input wire logic                 hdr_ready,
  input hhlp_pkg::hdr_item_t       hdr,
  input wire logic                 res_valid,
  input wire logic                 res_ready,
  input hhlp_pkg::res_item_t       res
);

  a_hdr_hold: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && !hdr_ready |=> hdr_valid && $stable(hdr))
    else $error("input item changed while waiting");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  a_len_only_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.event_res != hhlp_pkg::EV_LINE_DONE |->
      res.name_length == '0 && res.value_length == '0)
    else $error("lengths reported without a finished line");

  a_err_role: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.event_res == hhlp_pkg::EV_LINE_ERROR ||
                  res.event_res == hhlp_pkg::EV_INCOMPLETE) |->
      res.byte_role == hhlp_pkg::ROLE_IGNORED)
    else $error("error or incomplete item carries a role");

  a_done_delim: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.event_res == hhlp_pkg::EV_LINE_DONE ||
                  res.event_res == hhlp_pkg::EV_HDRS_DONE) |->
      res.byte_role == hhlp_pkg::ROLE_DELIM)
    else $error("line end not marked as delimiter");

endmodule

bind http_header_line_parser hhlp_checker u_hhlp_checker (
  .clk       (clk),
  .rst       (rst),
  .hdr_valid (hdr_valid),
  .hdr_ready (hdr_ready),
  .hdr       (hdr),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

`default_nettype wire

// ----- dv/http_header_line_parser_tb.sv -----
module http_header_line_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CmdParse   = 1'b0;
  localparam logic CmdRestart = 1'b1;
  localparam logic [7:0] ChNul = 8'h00;

  logic                clk;
  logic                rst;
  logic                hdr_valid;
  logic                hdr_ready;
  hhlp_pkg::hdr_item_t hdr;
  logic                res_valid;
  logic                res_ready;
  hhlp_pkg::res_item_t res;

  http_header_line_parser i_dut (
    .clk      (clk),
    .rst      (rst),
    .hdr_valid(hdr_valid),
    .hdr_ready(hdr_ready),
    .hdr      (hdr),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // parser state as seen by the predictor
  hhlp_pkg::phase_t phase;
  int               name_cnt;
  int               value_cnt;

  hhlp_pkg::res_item_t pending_results[$];
  int                  errors = 0;
  int                  items_sent = 0;
  bit                  tx_quiet = 1'b0;
  bit                  rx_quiet = 1'b0;
  int                  hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

  // everything printable except the colon is a legal name byte
  function automatic bit is_name_byte(logic [7:0] c);
    return c >= hhlp_pkg::ChLow && c <= hhlp_pkg::ChHigh && c != hhlp_pkg::ChColon;
  endfunction

  function automatic bit is_vchar(logic [7:0] c);
    return c >= hhlp_pkg::ChLow && c <= hhlp_pkg::ChHigh;
  endfunction

  function automatic bit is_gap(logic [7:0] c);
    return c == hhlp_pkg::ChSpace || c == hhlp_pkg::ChTab;
  endfunction

  function automatic int bump(int n);
    return (n < hhlp_pkg::LengthMax) ? n + 1 : hhlp_pkg::LengthMax;
  endfunction

  function automatic hhlp_pkg::res_item_t parse_byte(hhlp_pkg::hdr_item_t it);
    hhlp_pkg::res_item_t r;
    logic [7:0]          c;
    bit                  line_end;
    bit                  bad;
    r.byte_role    = hhlp_pkg::ROLE_IGNORED;
    r.event_res    = hhlp_pkg::EV_NONE;
    r.name_length  = '0;
    r.value_length = '0;
    c        = it.data_byte;
    line_end = 1'b0;
    bad      = 1'b0;
    if (it.command == CmdRestart) begin
      phase     = hhlp_pkg::PH_START;
      name_cnt  = 0;
      value_cnt = 0;
    end else if (phase == hhlp_pkg::PH_DONE) begin
      r.event_res = hhlp_pkg::EV_NONE;
    end else if (c == ChNul) begin
      r.event_res = hhlp_pkg::EV_INCOMPLETE;
    end else begin
      case (phase)
        hhlp_pkg::PH_START: begin
          if (is_name_byte(c)) begin
            phase       = hhlp_pkg::PH_NAME;
            name_cnt    = 1;
            value_cnt   = 0;
            r.byte_role = hhlp_pkg::ROLE_NAME;
          end else if (c == hhlp_pkg::ChCr || c == hhlp_pkg::ChLf) begin
            phase       = hhlp_pkg::PH_DONE;
            r.byte_role = hhlp_pkg::ROLE_DELIM;
            r.event_res = hhlp_pkg::EV_HDRS_DONE;
          end else begin
            bad = 1'b1;
          end
        end
        hhlp_pkg::PH_NAME: begin
          if (is_name_byte(c)) begin
            name_cnt    = bump(name_cnt);
            r.byte_role = hhlp_pkg::ROLE_NAME;
          end else if (c == hhlp_pkg::ChColon) begin
            phase       = hhlp_pkg::PH_COLON;
            r.byte_role = hhlp_pkg::ROLE_DELIM;
          end else begin
            bad = 1'b1;
          end
        end
        hhlp_pkg::PH_COLON, hhlp_pkg::PH_GAP: begin
          if (phase == hhlp_pkg::PH_COLON && c == hhlp_pkg::ChColon) begin
            r.byte_role = hhlp_pkg::ROLE_DELIM;
          end else if (is_gap(c)) begin
            phase       = hhlp_pkg::PH_GAP;
            r.byte_role = hhlp_pkg::ROLE_DELIM;
          end else if (is_vchar(c)) begin
            phase       = hhlp_pkg::PH_VALUE;
            value_cnt   = 1;
            r.byte_role = hhlp_pkg::ROLE_VALUE;
          end else if (c == hhlp_pkg::ChCr) begin
            phase       = hhlp_pkg::PH_WAITLF;
            r.byte_role = hhlp_pkg::ROLE_DELIM;
          end else if (c == hhlp_pkg::ChLf) begin
            r.byte_role = hhlp_pkg::ROLE_DELIM;
            line_end    = 1'b1;
          end else begin
            bad = 1'b1;
          end
        end
        hhlp_pkg::PH_VALUE: begin
          if (is_vchar(c) || is_gap(c)) begin
            value_cnt   = bump(value_cnt);
            r.byte_role = hhlp_pkg::ROLE_VALUE;
          end else if (c == hhlp_pkg::ChCr) begin
            phase       = hhlp_pkg::PH_WAITLF;
            r.byte_role = hhlp_pkg::ROLE_DELIM;
          end else if (c == hhlp_pkg::ChLf) begin
            r.byte_role = hhlp_pkg::ROLE_DELIM;
            line_end    = 1'b1;
          end else begin
            bad = 1'b1;
          end
        end
        hhlp_pkg::PH_WAITLF: begin
          if (c == hhlp_pkg::ChLf) begin
            r.byte_role = hhlp_pkg::ROLE_DELIM;
            line_end    = 1'b1;
          end else begin
            bad = 1'b1;
          end
        end
        default: begin
          if (c == hhlp_pkg::ChLf) begin
            phase       = hhlp_pkg::PH_START;
            r.byte_role = hhlp_pkg::ROLE_DELIM;
          end
        end
      endcase
      if (line_end) begin
        r.event_res    = hhlp_pkg::EV_LINE_DONE;
        r.name_length  = hhlp_pkg::LenW'(name_cnt);
        r.value_length = hhlp_pkg::LenW'(value_cnt);
        phase          = hhlp_pkg::PH_START;
        name_cnt       = 0;
        value_cnt      = 0;
      end else if (bad) begin
        r.event_res = hhlp_pkg::EV_LINE_ERROR;
        r.byte_role = hhlp_pkg::ROLE_IGNORED;
        phase       = (c == hhlp_pkg::ChLf) ? hhlp_pkg::PH_START : hhlp_pkg::PH_SKIP;
        name_cnt    = 0;
        value_cnt   = 0;
      end
    end
    return r;
  endfunction

  task automatic send_item(input logic cmd, input logic [7:0] b);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      hdr_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    hdr_valid <= 1'b1;
    hdr       <= '{command: cmd, data_byte: b};
    do begin
      @(posedge clk);
    end while (!hdr_ready);
    pending_results.push_back(parse_byte('{command: cmd, data_byte: b}));
    items_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_item(CmdParse, s[i]);
  endtask

  // line content, now and then preceded by a zero byte or corrupted
  task automatic send_data(input logic [7:0] b);
    if ($urandom_range(0, 29) == 0) send_item(CmdParse, ChNul);
    if ($urandom_range(0, 59) == 0) b = 8'($urandom_range(0, 255));
    send_item(CmdParse, b);
  endtask

  task automatic drain();
    @(negedge clk);
    hdr_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] draw_name_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(hhlp_pkg::ChLow, hhlp_pkg::ChHigh));
    while (c == hhlp_pkg::ChColon);
    return c;
  endfunction

  function automatic logic [7:0] draw_value_byte();
    if ($urandom_range(0, 7) == 0)
      return $urandom_range(0, 1) ? hhlp_pkg::ChSpace : hhlp_pkg::ChTab;
    return 8'($urandom_range(hhlp_pkg::ChLow, hhlp_pkg::ChHigh));
  endfunction

  task automatic test_directed();
    send_item(CmdRestart, 8'hFF);
    send_text("A::");
    send_item(CmdParse, hhlp_pkg::ChTab);
    send_item(CmdParse, hhlp_pkg::ChCr);
    send_item(CmdParse, hhlp_pkg::ChLf);
    send_text("B");
    send_item(CmdParse, ChNul);
    send_text(":v");
    send_item(CmdParse, hhlp_pkg::ChLf);
    send_text("C:");
    send_item(CmdParse, hhlp_pkg::ChLf);
    send_text("D");
    send_item(CmdParse, hhlp_pkg::ChLf);
    send_item(CmdParse, 8'hFF);
    send_text("x");
    send_item(CmdParse, hhlp_pkg::ChLf);
    send_text("E:");
    send_item(CmdParse, hhlp_pkg::ChCr);
    send_text("q");
    send_item(CmdParse, hhlp_pkg::ChLf);
    send_item(CmdParse, hhlp_pkg::ChCr);
    send_item(CmdParse, ChNul);
    send_text("Z");
    send_item(CmdRestart, ChNul);
    send_item(CmdParse, hhlp_pkg::ChLf);
    send_item(CmdRestart, 8'h55);
    drain();
  endtask

  task automatic test_backpressure();
    tx_quiet    = 1'b1;
    hold_cycles = 80;
    repeat (4) begin
      send_text("Accept: text/html");
      send_item(CmdParse, hhlp_pkg::ChCr);
      send_item(CmdParse, hhlp_pkg::ChLf);
    end
    drain();
    tx_quiet = 1'b0;
  endtask

  task automatic send_random_line();
    int n;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 10)) send_item(CmdParse, 8'($urandom_range(0, 255)));
      send_item(CmdParse, hhlp_pkg::ChLf);
      return;
    end
    n = $urandom_range(1, 12);
    repeat (n) send_data(draw_name_byte());
    send_data(hhlp_pkg::ChColon);
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) send_data(hhlp_pkg::ChColon);
    repeat ($urandom_range(0, 2))
      send_data($urandom_range(0, 1) ? hhlp_pkg::ChSpace : hhlp_pkg::ChTab);
    repeat ($urandom_range(0, 16)) send_data(draw_value_byte());
    case ($urandom_range(0, 3))
      0: send_item(CmdParse, hhlp_pkg::ChLf);
      3: begin
        send_item(CmdParse, hhlp_pkg::ChCr);
        send_item(CmdParse, 8'($urandom_range(0, 255)));
        send_item(CmdParse, hhlp_pkg::ChLf);
      end
      default: begin
        send_item(CmdParse, hhlp_pkg::ChCr);
        send_item(CmdParse, hhlp_pkg::ChLf);
      end
    endcase
  endtask

  task automatic test_random_blocks();
    int stop_at;
    int blk;
    stop_at = items_sent + 1800;
    blk     = 0;
    while (items_sent < stop_at) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if (phase == hhlp_pkg::PH_DONE || $urandom_range(0, 1) == 0)
        send_item(CmdRestart, 8'($urandom_range(0, 255)));
      repeat ($urandom_range(1, 6)) send_random_line();
      if ($urandom_range(0, 1) == 0) send_item(CmdParse, hhlp_pkg::ChCr);
      send_item(CmdParse, hhlp_pkg::ChLf);
      repeat ($urandom_range(0, 3)) send_item(CmdParse, 8'($urandom_range(0, 255)));
      blk++;
      if (blk % 10 == 0) drain();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    drain();
  endtask

  initial begin : result_sink
    int stall;
    res_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
        res_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      stall = rx_quiet ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ready <= 1'b1;
      do begin
        @(posedge clk);
      end while (!res_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    hhlp_pkg::res_item_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (res.byte_role !== want.byte_role) begin
          $error("byte_role: expected %0d, got %0d", want.byte_role, res.byte_role);
          errors++;
        end
        if (res.event_res !== want.event_res) begin
          $error("event_res: expected %0d, got %0d", want.event_res, res.event_res);
          errors++;
        end
        if (res.name_length !== want.name_length) begin
          $error("name_length: expected %0d, got %0d", want.name_length, res.name_length);
          errors++;
        end
        if (res.value_length !== want.value_length) begin
          $error("value_length: expected %0d, got %0d", want.value_length,
                 res.value_length);
          errors++;
        end
      end
    end
  end

  initial begin
    rst       = 1'b1;
    hdr_valid = 1'b0;
    hdr       = '0;
    phase     = hhlp_pkg::PH_START;
    name_cnt  = 0;
    value_cnt = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random_blocks();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
